FILE: sv/mrt_pkg.sv
`timescale 1ns / 1ps

package mrt_pkg;

    localparam int FIELD_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_OUT_W    = 7;
    localparam int DEF_MAX_RANGES = 64;
    localparam int DEF_NUM_WIDTH  = 32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // read address source
    typedef enum logic [2:0] {
        RD_ZERO     = 3'd0,
        RD_K_NEXT   = 3'd1,
        RD_CNT_LAST = 3'd2,
        RD_J_PREV   = 3'd3,
        RD_J_SKIP   = 3'd4
    } rd_sel_t;

    // write address and data source
    typedef enum logic [2:0] {
        WR_APPEND   = 3'd0,
        WR_TRIM     = 3'd1,
        WR_SPLIT_LO = 3'd2,
        WR_SPLIT_HI = 3'd3,
        WR_SHUP     = 3'd4,
        WR_SHDN     = 3'd5
    } wr_sel_t;

    typedef enum logic [1:0] {
        K_HOLD = 2'd0,
        K_ZERO = 2'd1,
        K_INC  = 2'd2
    } k_op_t;

    typedef enum logic [2:0] {
        J_HOLD     = 3'd0,
        J_K        = 3'd1,
        J_CNT_LAST = 3'd2,
        J_DEC      = 3'd3,
        J_INC      = 3'd4
    } j_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef struct packed {
        logic    load_p;
        logic    cap_e;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        k_op_t   k_op;
        j_op_t   j_op;
        cnt_op_t cnt_op;
        logic    res_load;
        status_t res_status;
    } mrt_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic k_has_next;
        logic p_lt_s;
        logic p_ge_e;
        logic p_edge;
        logic trim_empty;
        logic j_above_next;
        logic j_skip_ok;
        logic out_free;
    } mrt_stat_t;

endpackage

FILE: sv/missing_range_tracker.sv
`timescale 1ns / 1ps

// Missing-range tracker: keeps up to MAX_RANGES half-open ranges [start,end)
// in one RAM with a write port and a registered read port, and takes one
// transaction at a time. An append goes from acceptance to S_RESP, which
// loads the result register once the output register is free. A fill reads
// one entry per cycle while scanning, then moves one entry per cycle when a
// range is split or removed; a split writes its high half in S_SPLIT_HI.
// A fill also loads its result from S_RESP. Scanned plus moved entries
// never exceed the range count. The single RAM write port sets the shift
// rate. Input stall drops as soon as the previous result has been placed
// in the output register, even while that result is still stalled. The
// next transaction can then be accepted in the cycle after that load. The
// range tables need no clearing after reset; only entries below the range
// count are ever read.
// status: 0 done, 1 point in no range, 2 table full.
module missing_range_tracker #(
    parameter int MAX_RANGES = mrt_pkg::DEF_MAX_RANGES,
    parameter int NUM_WIDTH  = mrt_pkg::DEF_NUM_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [mrt_pkg::FIELD_W-1:0]      gap_start,
    input  logic [mrt_pkg::FIELD_W-1:0]      gap_end,
    input  logic [mrt_pkg::FIELD_W-1:0]      point,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mrt_pkg::STATUS_W-1:0]     status,
    output logic [mrt_pkg::COUNT_OUT_W-1:0]  range_count
);

    import mrt_pkg::*;

    mrt_cmd_t  cmd;
    mrt_stat_t st;

    mrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .st       (st),
        .cmd      (cmd)
    );

    mrt_dp #(
        .MAX_RANGES (MAX_RANGES),
        .NUM_WIDTH  (NUM_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .gap_start   (gap_start),
        .gap_end     (gap_end),
        .point       (point),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .range_count (range_count)
    );

endmodule

FILE: sv/mrt_ram.sv
`timescale 1ns / 1ps

module mrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/mrt_ctrl.sv
`timescale 1ns / 1ps

module mrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  mrt_pkg::mrt_stat_t st,
    output mrt_pkg::mrt_cmd_t  cmd
);

    import mrt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SHUP     = 6'b000100,
        S_SPLIT_HI = 6'b001000,
        S_SHDN     = 6'b010000,
        S_RESP     = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    status_t result_reg, result_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        cmd.load_p     = 1'b0;
        cmd.cap_e      = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.rd_sel     = RD_ZERO;
        cmd.wr_en      = 1'b0;
        cmd.wr_sel     = WR_APPEND;
        cmd.k_op       = K_HOLD;
        cmd.j_op       = J_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.res_load   = 1'b0;
        cmd.res_status = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RESP;
                    if (opcode == OP_APPEND)
                    begin
                        if (st.full)
                        begin
                            result_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_APPEND;
                            cmd.cnt_op  = CNT_INC;
                            result_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        cmd.load_p = 1'b1;
                        if (st.cnt_zero)
                        begin
                            result_next = ST_NONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_ZERO;
                            cmd.k_op   = K_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            // entry k is on the RAM read port
            S_SCAN:
            begin
                cmd.cap_e = 1'b1;
                if (st.p_lt_s)
                begin
                    result_next = ST_NONE;
                    state_next  = S_RESP;
                end
                else if (st.p_ge_e)
                begin
                    if (st.k_has_next)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_K_NEXT;
                        cmd.k_op   = K_INC;
                    end
                    else
                    begin
                        result_next = ST_NONE;
                        state_next  = S_RESP;
                    end
                end
                else if (st.p_edge)
                begin
                    result_next = ST_DONE;
                    if (st.trim_empty)
                    begin
                        if (st.k_has_next)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_K_NEXT;
                            cmd.j_op   = J_K;
                            state_next = S_SHDN;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_TRIM;
                        state_next = S_RESP;
                    end
                end
                else if (st.full)
                begin
                    result_next = ST_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    // split: lower half stays at k, later entries move up
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SPLIT_LO;
                    if (st.k_has_next)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_CNT_LAST;
                        cmd.j_op   = J_CNT_LAST;
                        state_next = S_SHUP;
                    end
                    else
                    begin
                        state_next = S_SPLIT_HI;
                    end
                end
            end

            S_SHUP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHUP;
                if (st.j_above_next)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_J_PREV;
                    cmd.j_op   = J_DEC;
                end
                else
                begin
                    state_next = S_SPLIT_HI;
                end
            end

            S_SPLIT_HI:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SPLIT_HI;
                cmd.cnt_op  = CNT_INC;
                result_next = ST_DONE;
                state_next  = S_RESP;
            end

            S_SHDN:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHDN;
                if (st.j_skip_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_J_SKIP;
                    cmd.j_op   = J_INC;
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mrt_dp.sv
`timescale 1ns / 1ps

module mrt_dp #(
    parameter int MAX_RANGES = mrt_pkg::DEF_MAX_RANGES,
    parameter int NUM_WIDTH  = mrt_pkg::DEF_NUM_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mrt_pkg::FIELD_W-1:0]      gap_start,
    input  logic [mrt_pkg::FIELD_W-1:0]      gap_end,
    input  logic [mrt_pkg::FIELD_W-1:0]      point,
    input  mrt_pkg::mrt_cmd_t                cmd,
    output mrt_pkg::mrt_stat_t               st,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mrt_pkg::STATUS_W-1:0]     status,
    output logic [mrt_pkg::COUNT_OUT_W-1:0]  range_count
);

    import mrt_pkg::*;

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int CMP_W = CNT_W + 1;
    localparam int ENT_W = 2 * NUM_WIDTH;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [NUM_WIDTH-1:0]   p_reg;
    logic [NUM_WIDTH-1:0]   e_hold_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [COUNT_OUT_W-1:0] range_count_reg;

    logic [NUM_WIDTH+FIELD_W-1:0]   gs_ext, ge_ext, pt_ext;
    logic [NUM_WIDTH-1:0]           gs_n, ge_n, pt_n;
    logic [CNT_W+COUNT_OUT_W-1:0]   count_ext;

    logic [CMP_W-1:0] cnt_c, k_c, j_c, k_plus1, cnt_m1, j_plus1, j_minus1, j_plus2;

    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [ENT_W-1:0]     rd_data, wr_data;
    logic [NUM_WIDTH-1:0] s_cur, e_cur, trim_s, trim_e;
    logic                 p_eq_s, p_eq_last;

    // fold the fixed-width fields into the number width
    assign gs_ext = {{NUM_WIDTH{1'b0}}, gap_start};
    assign ge_ext = {{NUM_WIDTH{1'b0}}, gap_end};
    assign pt_ext = {{NUM_WIDTH{1'b0}}, point};
    assign gs_n   = gs_ext[NUM_WIDTH-1:0];
    assign ge_n   = ge_ext[NUM_WIDTH-1:0];
    assign pt_n   = pt_ext[NUM_WIDTH-1:0];

    assign cnt_c    = CMP_W'(count_reg);
    assign k_c      = CMP_W'(k_reg);
    assign j_c      = CMP_W'(j_reg);
    assign k_plus1  = k_c + CMP_W'(1);
    assign cnt_m1   = cnt_c - CMP_W'(1);
    assign j_plus1  = j_c + CMP_W'(1);
    assign j_minus1 = j_c - CMP_W'(1);
    assign j_plus2  = j_c + CMP_W'(2);

    assign s_cur = rd_data[ENT_W-1:NUM_WIDTH];
    assign e_cur = rd_data[NUM_WIDTH-1:0];

    assign p_eq_s    = (p_reg == s_cur);
    assign p_eq_last = (p_reg == (e_cur - NUM_WIDTH'(1)));

    always_comb
    begin
        if (p_eq_s)
        begin
            trim_s = s_cur + NUM_WIDTH'(1);
            trim_e = e_cur;
        end
        else
        begin
            trim_s = s_cur;
            trim_e = e_cur - NUM_WIDTH'(1);
        end
    end

    assign st.cnt_zero     = (count_reg == '0);
    assign st.full         = (cnt_c >= CMP_W'(MAX_RANGES));
    assign st.k_has_next   = (k_plus1 < cnt_c);
    assign st.p_lt_s       = (p_reg < s_cur);
    assign st.p_ge_e       = (p_reg >= e_cur);
    assign st.p_edge       = p_eq_s | p_eq_last;
    assign st.trim_empty   = (trim_s >= trim_e);
    assign st.j_above_next = (j_c > k_plus1);
    assign st.j_skip_ok    = (j_plus2 < cnt_c);
    assign st.out_free     = !out_valid_reg || !out_stall;

    assign rd_en = cmd.rd_en;
    assign wr_en = cmd.wr_en;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO:     rd_addr = '0;
            RD_K_NEXT:   rd_addr = k_plus1[IDX_W-1:0];
            RD_CNT_LAST: rd_addr = cnt_m1[IDX_W-1:0];
            RD_J_PREV:   rd_addr = j_minus1[IDX_W-1:0];
            RD_J_SKIP:   rd_addr = j_plus2[IDX_W-1:0];
            default:     rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_addr = cnt_c[IDX_W-1:0];
                wr_data = {gs_n, ge_n};
            end
            WR_TRIM:
            begin
                wr_addr = k_reg;
                wr_data = {trim_s, trim_e};
            end
            WR_SPLIT_LO:
            begin
                wr_addr = k_reg;
                wr_data = {s_cur, p_reg};
            end
            WR_SPLIT_HI:
            begin
                wr_addr = k_plus1[IDX_W-1:0];
                wr_data = {p_reg + NUM_WIDTH'(1), e_hold_reg};
            end
            WR_SHUP:
            begin
                wr_addr = j_plus1[IDX_W-1:0];
                wr_data = rd_data;
            end
            WR_SHDN:
            begin
                wr_addr = j_reg;
                wr_data = rd_data;
            end
            default:
            begin
                wr_addr = k_reg;
                wr_data = rd_data;
            end
        endcase
    end

    mrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase

        case (cmd.k_op)
            K_ZERO:  k_next = '0;
            K_INC:   k_next = k_plus1[IDX_W-1:0];
            default: k_next = k_reg;
        endcase

        case (cmd.j_op)
            J_K:        j_next = k_reg;
            J_CNT_LAST: j_next = cnt_m1[IDX_W-1:0];
            J_DEC:      j_next = j_minus1[IDX_W-1:0];
            J_INC:      j_next = j_plus1[IDX_W-1:0];
            default:    j_next = j_reg;
        endcase
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        j_reg <= j_next;
        if (cmd.load_p)
        begin
            p_reg <= pt_n;
        end
        if (cmd.cap_e)
        begin
            e_hold_reg <= e_cur;
        end
        if (cmd.res_load)
        begin
            status_reg      <= cmd.res_status;
            range_count_reg <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign range_count = range_count_reg;

endmodule
